>>> rtl/tct_pkg.sv
// Shared types, constants and the coordinate mapping of the contact tracker.
`timescale 1ns / 1ps

package tct_pkg;

    localparam int POINT_CAP  = 10;
    localparam int TRACK_IDS  = 16;
    localparam int ID_W       = 4;
    localparam int COORD_W    = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [7:0] READY_BIT  = 8'(1 << 7);
    localparam logic [3:0] COUNT_MASK = 4'h0f;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd5;

    typedef enum logic [1:0] {
        EV_DOWN  = 2'd0,
        EV_MOVE  = 2'd1,
        EV_UP    = 2'd2,
        EV_ERROR = 2'd3
    } t_event_kind;

    // One stored contact entry
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] area;
    } t_contact;

    // Write and read requests toward the contact store
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] addr;
        t_contact        data;
    } t_store_wr;

    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] addr;
    } t_store_rd;

    // Clamp to resolution and optionally mirror; zero resolution passes through
    function automatic logic [COORD_W-1:0] map_axis(
        input logic [COORD_W-1:0] v,
        input logic [COORD_W-1:0] res,
        input logic               mirror
    );
        logic [COORD_W-1:0] t;
        t = v;
        if (res != '0) begin
            if (t >= res) begin
                t = res - 1'b1;
            end
            if (mirror) begin
                t = res - 1'b1 - t;
            end
        end
        return t;
    endfunction

endpackage

>>> rtl/tct_store.sv
// Contact position and size memory, one write and one registered read port.
`timescale 1ns / 1ps

module tct_store
    import tct_pkg::*;
(
    input  logic      i_clk,
    input  t_store_wr i_wr,
    input  t_store_rd i_rd,
    output t_contact  o_rd_data
);

    t_contact r_mem [TRACK_IDS];
    t_contact r_rd_data;

    // Write the entry of a record, read one entry for a release
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/touch_contact_tracker.sv
// Top level of the contact tracker: frame parsing, event output and release sweep.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------------
//   in      | input     | i_in_valid / o_in_stall    | command, status, record fields
//   out     | output    | o_out_valid / i_out_stall  | kind, id, position, area, last
//   cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A status byte or a record is taken while the input is not stalled; its event goes to the output register.
// Each release is a contact memory read, then a load of the output register.
// Synchronous active-low reset clears masks, counters and the output valid bit.
// A stalled output holds the input off; no item is taken during a release sweep.
`timescale 1ns / 1ps

module touch_contact_tracker
    import tct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [7:0]           i_status_byte,
    input  logic [7:0]           i_track_byte,
    input  logic [COORD_W-1:0]   i_raw_x,
    input  logic [COORD_W-1:0]   i_raw_y,
    input  logic [COORD_W-1:0]   i_contact_area,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_event_kind,
    output logic [ID_W-1:0]      o_contact_id,
    output logic [COORD_W-1:0]   o_pos_x,
    output logic [COORD_W-1:0]   o_pos_y,
    output logic [COORD_W-1:0]   o_area,
    output logic                 o_last,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP_RD,
        ST_SWEEP_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic               r_swap_axes;
    logic               r_mirror_x;
    logic               r_mirror_y;
    logic [COORD_W-1:0] r_width;
    logic [COORD_W-1:0] r_height;
    logic [3:0]         r_point_limit;

    // frame state
    logic [TRACK_IDS-1:0] r_active;
    logic [TRACK_IDS-1:0] r_seen;
    logic [3:0]           r_records_left;
    logic                 r_skip;
    logic [ID_W-1:0]      r_sw_id;

    // output register
    logic               r_o_valid;
    t_event_kind        r_kind;
    logic [ID_W-1:0]    r_id;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COORD_W-1:0] r_area;
    logic               r_last;

    logic                 out_free;
    logic                 in_acc;
    logic                 out_load;
    logic [3:0]           limit;
    logic [3:0]           count;
    logic [ID_W-1:0]      rec_id;
    logic [TRACK_IDS-1:0] rec_bit;
    logic                 rec_dup;
    logic                 rec_live;
    logic [3:0]           n_records_left;
    logic [TRACK_IDS-1:0] pend_after;
    logic                 rec_last;
    logic [COORD_W-1:0]   sx;
    logic [COORD_W-1:0]   sy;
    logic [COORD_W-1:0]   map_x;
    logic [COORD_W-1:0]   map_y;
    logic [TRACK_IDS-1:0] pend;
    logic [ID_W-1:0]      sweep_id;
    t_store_wr            st_wr;
    t_store_rd            st_rd;
    t_contact             st_rd_data;

    // Handshake
    assign out_free   = !r_o_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Status byte decode
    assign limit = (r_point_limit > 4'(POINT_CAP)) ? 4'(POINT_CAP) : r_point_limit;
    assign count = i_status_byte[3:0] & COUNT_MASK;

    // Record decode
    assign rec_id   = i_track_byte[ID_W-1:0];
    assign rec_bit  = TRACK_IDS'(1) << rec_id;
    assign rec_dup  = ({1'b0, rec_id} >= 5'(TRACK_IDS)) || ((r_seen & rec_bit) != '0);
    assign rec_live = i_command && (r_records_left != '0) && !r_skip;
    assign n_records_left = r_records_left - 1'b1;
    assign pend_after = r_active & ~r_seen & ~rec_bit;
    assign rec_last   = (n_records_left != '0) || (pend_after == '0);

    // Load the output register on a count error, a record event or a release
    assign out_load = (r_state == ST_SWEEP_OUT)
                   || (in_acc && !i_command && ((i_status_byte & READY_BIT) != '0)
                       && (count > limit))
                   || (in_acc && rec_live);

    // Swap, clamp and mirror
    assign sx    = r_swap_axes ? i_raw_y : i_raw_x;
    assign sy    = r_swap_axes ? i_raw_x : i_raw_y;
    assign map_x = map_axis(sx, r_width, r_mirror_x);
    assign map_y = map_axis(sy, r_height, r_mirror_y);

    // Pick the lowest contact still to release
    assign pend = r_active & ~r_seen;
    always_comb begin
        sweep_id = '0;
        for (int i = TRACK_IDS - 1; i >= 0; i--) begin
            if (pend[i]) begin
                sweep_id = ID_W'(i);
            end
        end
    end

    // Contact memory requests
    always_comb begin
        st_wr.en        = in_acc && rec_live && !rec_dup;
        st_wr.addr      = rec_id;
        st_wr.data.x    = map_x;
        st_wr.data.y    = map_y;
        st_wr.data.area = i_contact_area;
        st_rd.en        = (r_state == ST_SWEEP_RD) && out_free;
        st_rd.addr      = sweep_id;
    end

    tct_store u_store (
        .i_clk     (i_clk),
        .i_wr      (st_wr),
        .i_rd      (st_rd),
        .o_rd_data (st_rd_data)
    );

    // Control state, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_swap_axes    <= 1'b0;
            r_mirror_x     <= 1'b0;
            r_mirror_y     <= 1'b0;
            r_width        <= '0;
            r_height       <= '0;
            r_point_limit  <= 4'd10;
            r_active       <= '0;
            r_seen         <= '0;
            r_records_left <= '0;
            r_skip         <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SWAP_AXES: r_swap_axes   <= i_cfg_data[0];
                    CFG_MIRROR_X:  r_mirror_x    <= i_cfg_data[0];
                    CFG_MIRROR_Y:  r_mirror_y    <= i_cfg_data[0];
                    CFG_WIDTH:     r_width       <= i_cfg_data;
                    CFG_HEIGHT:    r_height      <= i_cfg_data;
                    CFG_LIMIT:     r_point_limit <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            // load a new result or drop a taken one
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && !i_command) begin
                        r_skip <= 1'b0;
                        r_seen <= '0;
                        if ((i_status_byte & READY_BIT) != '0) begin
                            if (count > limit) begin
                                r_records_left <= '0;
                                r_kind         <= EV_ERROR;
                                r_id           <= '0;
                                r_x            <= '0;
                                r_y            <= '0;
                                r_area         <= '0;
                                r_last         <= 1'b1;
                            end else if (count == '0) begin
                                r_records_left <= '0;
                                if (r_active != '0) begin
                                    r_state <= ST_SWEEP_RD;
                                end
                            end else begin
                                r_records_left <= count;
                            end
                        end else begin
                            r_records_left <= '0;
                        end
                    end else if (in_acc && (r_records_left != '0)) begin
                        r_records_left <= n_records_left;
                        if (!r_skip) begin
                            if (rec_dup) begin
                                r_skip <= 1'b1;
                                r_kind <= EV_ERROR;
                                r_id   <= '0;
                                r_x    <= '0;
                                r_y    <= '0;
                                r_area <= '0;
                                r_last <= 1'b1;
                            end else begin
                                r_seen   <= r_seen | rec_bit;
                                r_active <= r_active | rec_bit;
                                r_kind   <= ((r_active & rec_bit) != '0) ? EV_MOVE : EV_DOWN;
                                r_id     <= rec_id;
                                r_x      <= map_x;
                                r_y      <= map_y;
                                r_area   <= i_contact_area;
                                r_last   <= rec_last;
                                if (!rec_last) begin
                                    r_state <= ST_SWEEP_RD;
                                end
                            end
                        end
                    end
                end
                ST_SWEEP_RD: begin
                    // read the entry and retire the contact
                    if (out_free) begin
                        r_sw_id            <= sweep_id;
                        r_active[sweep_id] <= 1'b0;
                        r_state            <= ST_SWEEP_OUT;
                    end
                end
                ST_SWEEP_OUT: begin
                    // emit the release with its stored position
                    r_kind    <= EV_UP;
                    r_id      <= r_sw_id;
                    r_x       <= st_rd_data.x;
                    r_y       <= st_rd_data.y;
                    r_area    <= st_rd_data.area;
                    r_last    <= (pend == '0);
                    r_state   <= (pend == '0) ? ST_IDLE : ST_SWEEP_RD;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_event_kind = r_kind;
    assign o_contact_id = r_id;
    assign o_pos_x      = r_x;
    assign o_pos_y      = r_y;
    assign o_area       = r_area;
    assign o_last       = r_last;

endmodule
